// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk with reset rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/vsps_pkg.sv =====
// ----------------------------------------------------------------------------
// vsps_pkg
// Types, constants and the cell update function of the voxel shadow stamp.
// ----------------------------------------------------------------------------
package vsps_pkg;

  localparam int CELL_W   = 24;
  localparam int DECAY_W  = 17;
  localparam int LAYER_W  = 7;
  localparam int COORD_W  = 6;
  localparam int COUNT_W  = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = CELL_W + DECAY_W;

  // 0.01 in Q8.16 is 655.36, so the stamp ends below 656.
  localparam logic [CELL_W-1:0]  AMT_MIN  = 24'd656;
  localparam logic [CELL_W-1:0]  CELL_MAX = 24'hFFFFFF;
  localparam logic [DECAY_W-1:0] ONE_Q16  = 17'd65536;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_DECAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_DIVISOR = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              clip;
  } cell_upd_t;

  // Saturating add or flooring subtract of one layer amount.
  function automatic cell_upd_t cell_update(input logic [MODE_W-1:0] mode,
                                            input logic [CELL_W-1:0] old,
                                            input logic [CELL_W-1:0] amt);
    cell_upd_t     res;
    logic [CELL_W:0] sum;
    sum = {1'b0, old} + {1'b0, amt};
    if (mode == MODE_ADD) begin
      if (sum[CELL_W]) begin
        res.value = CELL_MAX;
        res.clip  = 1'b1;
      end else begin
        res.value = sum[CELL_W-1:0];
        res.clip  = 1'b0;
      end
    end else begin
      if (amt > old) begin
        res.value = '0;
        res.clip  = 1'b1;
      end else begin
        res.value = old - amt;
        res.clip  = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/vsps_grid.sv =====
// ----------------------------------------------------------------------------
// vsps_grid
// Shadow grid storage: one write and one registered read per cycle, with a
// clearing pass over every cell after reset, during which writes are ignored.
// ----------------------------------------------------------------------------
module vsps_grid #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [vsps_pkg::CELL_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [vsps_pkg::CELL_W-1:0] wr_data,
  output logic                       clr_busy
);
  import vsps_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/voxel_shadow_pyramid_stamp_core.sv =====
// ----------------------------------------------------------------------------
// voxel_shadow_pyramid_stamp_core
// Keeps a voxel shadow grid and applies pyramid stamps to it.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: s_tuser carries the mode (add stamp, remove
// stamp, read one cell), s_tdata the position. Each item gives exactly one
// result on the m_ stream. The user writes registers through cfg_we/cfg_addr/
// cfg_data only while the block is idle; the block does not enforce this.
// After reset the grid is cleared one cell per cycle, all GRID_X*GRID_Y*GRID_Z
// cells (32768 by default); s_tready stays low until that pass ends.
// A read passes through the read, read-wait and done steps. A stamp works
// layer by layer: a bounds step; if the layer touches the grid, a walk over
// its cells and a step to drain the last write; then a decay step. The done
// step follows the last layer. The grid is updated by one read-modify-write
// per cycle through the memory's single read port.
// One item is worked on at a time. A finished result waits in the output
// register while the next item is already taken in; if the receiver still
// stalls when the next result is ready, the block holds until the transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_shadow_pyramid_stamp_core #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pos_x, pos_y, pos_z, zero fill
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cell_value, cells_updated, clipped, zero fill
  input  logic        cfg_we,
  input  logic [vsps_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [23:0] cfg_data
);
  import vsps_pkg::*;

  localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = 3 * COORD_W;
  localparam int SPAN_W = COORD_W + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_RDW   = 3'd2;
  localparam logic [2:0] ST_LAYER = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_NEXT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Configuration registers.
  logic [CELL_W-1:0]  shadow_base;
  logic [DECAY_W-1:0] layer_decay;
  logic [LAYER_W-1:0] layer_limit;
  logic [LAYER_W-1:0] radius_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_base    <= 24'd65536;
      layer_decay    <= 17'd32768;
      layer_limit    <= 7'd8;
      radius_divisor <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHADOW_BASE:    shadow_base    <= cfg_data[CELL_W-1:0];
        REG_LAYER_DECAY:    layer_decay    <= cfg_data[DECAY_W-1:0];
        REG_LAYER_LIMIT:    layer_limit    <= cfg_data[LAYER_W-1:0];
        REG_RADIUS_DIVISOR: radius_divisor <= cfg_data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DECAY_W-1:0] decay_eff;
  logic [LAYER_W-1:0] div_eff;
  assign decay_eff = (layer_decay > ONE_Q16) ? ONE_Q16 : layer_decay;
  assign div_eff   = (radius_divisor == '0) ? 7'd1 : radius_divisor;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    logic [IDX_W-1:0] idx;
    idx = (IDX_W'(x) * IDX_W'(GRID_Y) + IDX_W'(y)) * IDX_W'(GRID_Z) + IDX_W'(z);
    return idx[ADDR_W-1:0];
  endfunction

  logic [2:0]         state;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] px, py, pz;
  logic [CELL_W-1:0]  amt;
  logic [PROD_W-1:0]  prod;
  logic [LAYER_W-1:0] q;
  logic [LAYER_W-1:0] r;
  logic [LAYER_W-1:0] rc;
  logic [COORD_W-1:0] cx, cy, wy0, wx1, wy1, zl;
  logic [CELL_W-1:0]  value;
  logic [COUNT_W-1:0] count;
  logic               clip;
  logic               pipe_v;
  logic [ADDR_W-1:0]  pipe_addr;

  logic [CELL_W-1:0]  rd_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               clr_busy;
  cell_upd_t          upd;

  // Layer bounds, clipped to the grid.
  logic [SPAN_W-1:0] px_w, py_w, r_w, x0, y0, x1, y1, xhi, yhi;
  logic              z_ok, layer_live, layer_hit, pos_in_grid;

  always_comb begin
    px_w = SPAN_W'(px);
    py_w = SPAN_W'(py);
    r_w  = SPAN_W'(r);
    x0   = (px_w >= r_w) ? px_w - r_w : '0;
    y0   = (py_w >= r_w) ? py_w - r_w : '0;
    xhi  = px_w + r_w;
    yhi  = py_w + r_w;
    x1   = (xhi > SPAN_W'(GRID_X - 1)) ? SPAN_W'(GRID_X - 1) : xhi;
    y1   = (yhi > SPAN_W'(GRID_Y - 1)) ? SPAN_W'(GRID_Y - 1) : yhi;
    z_ok = (q <= LAYER_W'(pz)) &&
           (SPAN_W'(LAYER_W'(pz) - q) < SPAN_W'(GRID_Z));
    layer_live = (q < layer_limit) && (amt >= AMT_MIN);
    layer_hit  = z_ok && (x0 <= x1) && (y0 <= y1);
    pos_in_grid = ((COORD_W + 1)'(px) < (COORD_W + 1)'(GRID_X)) &&
                  ((COORD_W + 1)'(py) < (COORD_W + 1)'(GRID_Y)) &&
                  ((COORD_W + 1)'(pz) < (COORD_W + 1)'(GRID_Z));
  end

  assign s_tready = (state == ST_IDLE) && !clr_busy;
  assign rd_en    = (state == ST_WALK) || ((state == ST_RD) && pos_in_grid);
  assign rd_addr  = (state == ST_RD) ? cell_addr(px, py, pz) : cell_addr(cx, cy, zl);
  assign upd      = cell_update(mode, rd_data, amt);

  vsps_grid #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (pipe_v),
    .wr_addr  (pipe_addr),
    .wr_data  (upd.value),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pipe_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pipe_v <= (state == ST_WALK);
      // In the done step the new result takes the output register instead.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tuser == MODE_READ) begin
              state <= ST_RD;
            end else if (s_tuser == MODE_ADD || s_tuser == MODE_REMOVE) begin
              state <= ST_LAYER;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RD:    state <= ST_RDW;
        ST_RDW:   state <= ST_DONE;
        ST_LAYER: begin
          if (!layer_live) begin
            state <= ST_DONE;
          end else if (layer_hit) begin
            state <= ST_WALK;
          end else begin
            state <= ST_NEXT;
          end
        end
        ST_WALK: begin
          if (cy == wy1 && cx == wx1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_NEXT;
        ST_NEXT:  state <= ST_LAYER;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pipe_addr <= rd_addr;
    if (pipe_v) begin
      if (count != {COUNT_W{1'b1}}) begin
        count <= count + 1'b1;
      end
      if (upd.clip) begin
        clip <= 1'b1;
      end
    end
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          mode  <= s_tuser;
          px    <= s_tdata[5:0];
          py    <= s_tdata[11:6];
          pz    <= s_tdata[17:12];
          amt   <= shadow_base;
          q     <= '0;
          r     <= '0;
          rc    <= '0;
          value <= '0;
          count <= '0;
          clip  <= 1'b0;
        end
      end
      ST_RDW: value <= pos_in_grid ? rd_data : '0;
      ST_LAYER: begin
        prod <= PROD_W'(amt) * PROD_W'(decay_eff);
        cx   <= x0[COORD_W-1:0];
        cy   <= y0[COORD_W-1:0];
        wy0  <= y0[COORD_W-1:0];
        wx1  <= x1[COORD_W-1:0];
        wy1  <= y1[COORD_W-1:0];
        zl   <= COORD_W'(LAYER_W'(pz) - q);
      end
      ST_WALK: begin
        if (cy == wy1) begin
          cy <= wy0;
          cx <= cx + 1'b1;
        end else begin
          cy <= cy + 1'b1;
        end
      end
      ST_NEXT: begin
        // The product never exceeds the old amount, so its top bit is zero.
        amt <= prod[CELL_W+15:16];
        q   <= q + 1'b1;
        if (rc == div_eff - 7'd1) begin
          rc <= '0;
          r  <= r + 1'b1;
        end else begin
          rc <= rc + 1'b1;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {7'd0, clip, count, value};
        end
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_no_accept_clearing, clr_busy |-> !s_tready, "input taken during clear pass")
  `ASSERT_CLK(a_walk_in_bounds, (state == ST_WALK) |-> (cx <= wx1 && cy <= wy1),
              "cell cursor outside the layer square")
  `ASSERT_CLK(a_result_from_done, $rose(m_tvalid) |-> $past(state) == ST_DONE,
              "result presented outside the done step")
  `ASSERT_CLK(a_write_in_walk, pipe_v |-> (state == ST_WALK || state == ST_DRAIN),
              "grid write outside a layer walk")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel shadow pyramid stamp core.
// A directed set of stamps and reads under boundary register settings is
// followed by random traffic under six random settings, four with random
// idling on both streams. Each result is checked against a shadow grid kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import vsps_pkg::*;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } stamp_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_value;
    logic [COUNT_W-1:0] cells_updated;
    logic               clipped;
  } stamp_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [23:0] cfg_data = '0;

  // Register values as the core holds them.
  logic [CELL_W-1:0]  cfg_base    = 24'd65536;
  logic [DECAY_W-1:0] cfg_decay   = 17'd32768;
  logic [LAYER_W-1:0] cfg_limit   = 7'd8;
  logic [LAYER_W-1:0] cfg_divisor = 7'd2;

  logic [CELL_W-1:0] shadow_mirror [GRID_CELLS];
  stamp_req_t        pending_items [$];
  stamp_res_t        expected_results [$];
  stamp_req_t        on_bus;

  int send_idle_pct = 21;
  int recv_idle_pct = 47;
  int n_issued = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int n_add = 0;
  int n_remove = 0;
  int n_read = 0;
  int n_unused = 0;

  voxel_shadow_pyramid_stamp_core #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(input string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR at %0t ns: %s", $time, what);
  endfunction

  // Applies one item to the shadow grid and returns the result it must give.
  function automatic stamp_res_t apply_stamp(input stamp_req_t req);
    stamp_res_t        res;
    logic [CELL_W-1:0] amt;
    logic [DECAY_W-1:0] decay;
    logic [PROD_W-1:0] prod;
    logic [CELL_W:0]   sum;
    int div, q, r, px, py, pz, z, x0, x1, y0, y1, x, y, idx;
    res = '0;
    px = int'(req.x);
    py = int'(req.y);
    pz = int'(req.z);
    if (req.mode == MODE_READ) begin
      if (px < GRID_X && py < GRID_Y && pz < GRID_Z)
        res.cell_value = shadow_mirror[(px * GRID_Y + py) * GRID_Z + pz];
    end else if (req.mode == MODE_ADD || req.mode == MODE_REMOVE) begin
      decay = (cfg_decay > ONE_Q16) ? ONE_Q16 : cfg_decay;
      div = (cfg_divisor == 0) ? 1 : int'(cfg_divisor);
      amt = cfg_base;
      for (q = 0; q < int'(cfg_limit); q++) begin
        if (amt < AMT_MIN) break;
        r = q / div;
        z = pz - q;
        if (z >= 0 && z < GRID_Z) begin
          x0 = (px - r < 0) ? 0 : px - r;
          x1 = (px + r > GRID_X - 1) ? GRID_X - 1 : px + r;
          y0 = (py - r < 0) ? 0 : py - r;
          y1 = (py + r > GRID_Y - 1) ? GRID_Y - 1 : py + r;
          for (x = x0; x <= x1; x++) begin
            for (y = y0; y <= y1; y++) begin
              idx = (x * GRID_Y + y) * GRID_Z + z;
              if (req.mode == MODE_ADD) begin
                sum = {1'b0, shadow_mirror[idx]} + {1'b0, amt};
                if (sum > {1'b0, CELL_MAX}) begin
                  shadow_mirror[idx] = CELL_MAX;
                  res.clipped = 1'b1;
                end else begin
                  shadow_mirror[idx] = sum[CELL_W-1:0];
                end
              end else if (amt > shadow_mirror[idx]) begin
                shadow_mirror[idx] = '0;
                res.clipped = 1'b1;
              end else begin
                shadow_mirror[idx] = shadow_mirror[idx] - amt;
              end
              if (res.cells_updated != 16'hFFFF) res.cells_updated++;
            end
          end
        end
        prod = amt * decay;
        amt = prod[16 +: CELL_W];
      end
    end
    return res;
  endfunction

  function automatic void add_item(input logic [MODE_W-1:0] mode, input int x, y, z);
    stamp_req_t req;
    req.mode = mode;
    req.x = COORD_W'(x);
    req.y = COORD_W'(y);
    req.z = COORD_W'(z);
    pending_items.push_back(req);
    n_issued++;
  endfunction

  // Mostly inside the grid, now and then anywhere in the field range.
  function automatic int rand_coord(input int extent);
    return int'(($urandom_range(99) < 85) ? $urandom_range(0, extent - 1)
                                          : $urandom_range(0, 63));
  endfunction

  task automatic wait_drained();
    while (n_results < n_issued) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] base_w, decay_w, limit_w, divisor_w);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_SHADOW_BASE;
    cfg_data <= base_w;
    @(posedge clk);
    cfg_addr <= REG_LAYER_DECAY;
    cfg_data <= decay_w;
    @(posedge clk);
    cfg_addr <= REG_LAYER_LIMIT;
    cfg_data <= limit_w;
    @(posedge clk);
    cfg_addr <= REG_RADIUS_DIVISOR;
    cfg_data <= divisor_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_base    = base_w;
    cfg_decay   = decay_w[DECAY_W-1:0];
    cfg_limit   = limit_w[LAYER_W-1:0];
    cfg_divisor = divisor_w[LAYER_W-1:0];
    n_settings++;
  endtask

  // Input side: the expectation is formed at the edge where the transfer
  // happens, so the grid copy follows the order the core works in.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_stamp(on_bus));
        case (on_bus.mode)
          MODE_ADD:    n_add++;
          MODE_REMOVE: n_remove++;
          MODE_READ:   n_read++;
          default:     n_unused++;
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, on_bus.z, on_bus.y, on_bus.x};
          s_tuser  <= on_bus.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    stamp_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.cell_value    = m_tdata[23:0];
      got.cells_updated = m_tdata[39:24];
      got.clipped       = m_tdata[40];
      n_results <= n_results + 1;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result %h with nothing outstanding", m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.cell_value !== want.cell_value)
          note_failure($sformatf("cell_value: expected %h, got %h",
                                 want.cell_value, got.cell_value));
        if (got.cells_updated !== want.cells_updated)
          note_failure($sformatf("cells_updated: expected %0d, got %0d",
                                 want.cells_updated, got.cells_updated));
        if (got.clipped !== want.clipped)
          note_failure($sformatf("clipped: expected %b, got %b",
                                 want.clipped, got.clipped));
      end
    end
  end

  initial begin
    logic [23:0] base_w, decay_w, limit_w, divisor_w;
    int ph, k, pick, div_v, lim_v, decay_v;
    logic [MODE_W-1:0] mode;
    foreach (shadow_mirror[i]) shadow_mirror[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one unit on top, halving per layer, 8 layers, q/2 wide.
    @(negedge clk);
    add_item(MODE_READ, 0, 0, 0);
    add_item(MODE_ADD, 31, 31, 31);
    add_item(MODE_ADD, 0, 0, 3);
    add_item(MODE_READ, 0, 0, 3);
    add_item(MODE_REMOVE, 0, 0, 3);
    add_item(MODE_REMOVE, 0, 0, 3);
    add_item(MODE_ADD, 63, 63, 63);
    add_item(MODE_ADD, 40, 16, 35);
    add_item(MODE_ADD, 16, 16, 20);
    add_item(MODE_READ, 16, 16, 18);
    add_item(MODE_UNUSED, 5, 5, 5);
    add_item(MODE_READ, 32, 5, 5);
    wait_drained();

    // No layers at all; the decay write carries junk above its 17 bits.
    apply_settings(24'd656, 24'hFE8000, 24'd0, 24'd2);
    @(negedge clk);
    add_item(MODE_ADD, 10, 10, 10);
    wait_drained();

    // Amount exactly at the stop threshold, zero decay ends after one layer.
    apply_settings(24'd656, 24'd0, 24'd64, 24'd127);
    @(negedge clk);
    add_item(MODE_ADD, 8, 8, 8);
    add_item(MODE_READ, 8, 8, 8);
    wait_drained();

    // Full-scale amount, decay above one, zero divisor: the stamp fills the
    // grid below it, then saturates, then drains to exactly zero and floors.
    apply_settings(24'hFFFFFF, 24'h01FFFF, 24'd127, 24'd0);
    @(negedge clk);
    add_item(MODE_ADD, 16, 16, 31);
    add_item(MODE_ADD, 16, 16, 31);
    add_item(MODE_READ, 16, 16, 0);
    add_item(MODE_REMOVE, 16, 16, 31);
    add_item(MODE_REMOVE, 16, 16, 31);
    wait_drained();

    // Just below the threshold nothing is stamped.
    apply_settings(24'd655, 24'd65536, 24'd64, 24'd1);
    @(negedge clk);
    add_item(MODE_ADD, 3, 3, 3);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: base_w = 24'($urandom_range(0, 2000));
        1: base_w = 24'($urandom_range(65536, 1048576));
        2: base_w = 24'($urandom);
        default: base_w = 24'(32'hFFFFFF - $urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0: decay_v = $urandom_range(0, 16383);
        1: decay_v = $urandom_range(65537, 131071);
        2: decay_v = 65536;
        default: decay_v = $urandom_range(16384, 65535);
      endcase
      // Narrow pyramids may run deeper; wide ones are kept short.
      div_v = $urandom_range(0, 8);
      lim_v = (div_v <= 2) ? $urandom_range(0, 6) : $urandom_range(0, 10);
      decay_w   = 24'(($urandom & 32'hFE0000) | decay_v);
      limit_w   = 24'(($urandom & 32'hFFFF80) | lim_v);
      divisor_w = 24'(($urandom & 32'hFFFF80) | div_v);
      apply_settings(base_w, decay_w, limit_w, divisor_w);
      @(negedge clk);
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 21 : 0;
      for (k = 0; k < 250; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) mode = MODE_ADD;
        else if (pick < 70) mode = MODE_REMOVE;
        else if (pick < 95) mode = MODE_READ;
        else mode = MODE_UNUSED;
        add_item(mode, rand_coord(GRID_X), rand_coord(GRID_Y), rand_coord(GRID_Z));
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d adds, %0d removes, %0d reads and %0d unused-mode items under %0d settings.",
             n_add, n_remove, n_read, n_unused, n_settings + 1);
    $display("Checked %0d results, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d of %0d results in.", n_results, n_issued);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
